@@ design/cbc_pkg.sv @@
// Shared widths, register indexes, reset values, item types and a remainder helper for the blob centroid block.
package cbc_pkg;

  // Default largest frame side in pixels
  localparam int unsigned MaxFrameDimDefault = 4096;

  // Field and register widths
  localparam int unsigned PixW     = 16;
  localparam int unsigned RedW     = 5;
  localparam int unsigned GreenW   = 6;
  localparam int unsigned BlueW    = 5;
  localparam int unsigned StrideW  = 5;
  localparam int unsigned DimW     = 13;
  localparam int unsigned CountW   = 25;
  localparam int unsigned SumW     = 48;
  localparam int unsigned CenterW  = 12;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 25;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRedMin       = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegGreenMax     = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegBlueMax      = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegRedOverBlue  = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegMinPixels    = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegSampleStride = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] RegFrameWidth   = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] RegFrameHeight  = CfgIdxW'(7);

  // Configuration reset values
  localparam logic [RedW-1:0]    RedMinReset      = RedW'(18);
  localparam logic [GreenW-1:0]  GreenMaxReset    = GreenW'(24);
  localparam logic [BlueW-1:0]   BlueMaxReset     = BlueW'(16);
  localparam logic [RedW-1:0]    RedOverBlueReset = RedW'(6);
  localparam logic [CountW-1:0]  MinPixelsReset   = CountW'(1500);
  localparam logic [StrideW-1:0] StrideReset      = StrideW'(4);
  localparam logic [DimW-1:0]    FrameWidthReset  = DimW'(1920);
  localparam logic [DimW-1:0]    FrameHeightReset = DimW'(1080);

  // Saturation value of the match counter
  localparam logic [CountW-1:0] CountMax = '1;

  // Thresholds captured with each item
  typedef struct packed {
    logic [RedW-1:0]    red_min;
    logic [GreenW-1:0]  green_max;
    logic [BlueW-1:0]   blue_max;
    logic [RedW-1:0]    red_over_blue;
    logic [StrideW-1:0] stride;
    logic [CountW-1:0]  min_pixels;
  } thr_t;

  // One pixel item as it leaves the front
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_start;
    logic            last;
    thr_t            thr;
  } item_t;

  // Frame totals handed to the divider
  typedef struct packed {
    logic [SumW-1:0]   sum_x;
    logic [SumW-1:0]   sum_y;
    logic [CountW-1:0] count;
    logic [CountW-1:0] min_pixels;
  } div_req_t;

  // One restoring remainder step: shift in a bit, subtract the stride if it fits
  function automatic logic [StrideW-1:0] rem_step(logic [StrideW-1:0] rem, logic b,
                                                  logic [StrideW-1:0] stride);
    logic [StrideW:0] trial;
    trial = {rem, b};
    if (trial >= {1'b0, stride}) begin
      trial = trial - {1'b0, stride};
    end
    return trial[StrideW-1:0];
  endfunction

endpackage

@@ design/cbc_fifo.sv @@
// Short item queue that decouples the front from the back.
module cbc_fifo #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [DataW-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [DataW-1:0] rd_data_o
);
  import cbc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [DataW-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CntW'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ design/cbc_front.sv @@
// Front end: configuration registers, raster position tracking and item capture.
module cbc_front #(
  parameter int unsigned MaxFrameDim = cbc_pkg::MaxFrameDimDefault,
  parameter int unsigned PosW        = $clog2(MaxFrameDim)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cbc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cbc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cbc_pkg::PixW-1:0]       pixel_value_i,
  input  logic                           frame_start_i,
  output logic                           q_valid_o,
  input  logic                           q_ready_i,
  output cbc_pkg::item_t                 q_item_o,
  output logic [PosW-1:0]                q_col_o,
  output logic [PosW-1:0]                q_row_o
);
  import cbc_pkg::*;

  logic [RedW-1:0]    red_min_q, red_min_d;
  logic [GreenW-1:0]  green_max_q, green_max_d;
  logic [BlueW-1:0]   blue_max_q, blue_max_d;
  logic [RedW-1:0]    rob_q, rob_d;
  logic [CountW-1:0]  min_pixels_q, min_pixels_d;
  logic [StrideW-1:0] stride_q, stride_d;
  logic [DimW-1:0]    width_q, width_d;
  logic [DimW-1:0]    height_q, height_d;

  logic [PosW-1:0] col_q, col_d, row_q, row_d;
  logic [PosW-1:0] col_cur, row_cur, last_col_idx, last_row_idx;
  logic            last_col, last_row, accept;

  // Last index of a side after clamping it to 1..MaxFrameDim
  function automatic logic [PosW-1:0] last_index(logic [DimW-1:0] dim);
    logic [PosW-1:0] idx;
    if (dim == '0) begin
      idx = '0;
    end else if (32'(dim) > 32'(MaxFrameDim)) begin
      idx = PosW'(MaxFrameDim - 1);
    end else begin
      idx = PosW'(dim - 1'b1);
    end
    return idx;
  endfunction

  assign cfg_ready_o = 1'b1;

  // Decode register writes; unknown indexes drop the write
  always_comb begin
    red_min_d    = red_min_q;
    green_max_d  = green_max_q;
    blue_max_d   = blue_max_q;
    rob_d        = rob_q;
    min_pixels_d = min_pixels_q;
    stride_d     = stride_q;
    width_d      = width_q;
    height_d     = height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRedMin:       red_min_d    = cfg_data_i[RedW-1:0];
        RegGreenMax:     green_max_d  = cfg_data_i[GreenW-1:0];
        RegBlueMax:      blue_max_d   = cfg_data_i[BlueW-1:0];
        RegRedOverBlue:  rob_d        = cfg_data_i[RedW-1:0];
        RegMinPixels:    min_pixels_d = cfg_data_i[CountW-1:0];
        RegSampleStride: stride_d     = cfg_data_i[StrideW-1:0];
        RegFrameWidth:   width_d      = cfg_data_i[DimW-1:0];
        RegFrameHeight:  height_d     = cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_min_q    <= RedMinReset;
      green_max_q  <= GreenMaxReset;
      blue_max_q   <= BlueMaxReset;
      rob_q        <= RedOverBlueReset;
      min_pixels_q <= MinPixelsReset;
      stride_q     <= StrideReset;
      width_q      <= FrameWidthReset;
      height_q     <= FrameHeightReset;
    end else begin
      red_min_q    <= red_min_d;
      green_max_q  <= green_max_d;
      blue_max_q   <= blue_max_d;
      rob_q        <= rob_d;
      min_pixels_q <= min_pixels_d;
      stride_q     <= stride_d;
      width_q      <= width_d;
      height_q     <= height_d;
    end
  end

  // Track column and row; frame start puts this pixel at the origin
  assign in_ready_o   = q_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign col_cur      = frame_start_i ? '0 : col_q;
  assign row_cur      = frame_start_i ? '0 : row_q;
  assign last_col_idx = last_index(width_q);
  assign last_row_idx = last_index(height_q);
  assign last_col     = (col_cur >= last_col_idx);
  assign last_row     = (row_cur >= last_row_idx);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (!last_col) begin
        col_d = col_cur + 1'b1;
        row_d = row_cur;
      end else if (!last_row) begin
        col_d = '0;
        row_d = row_cur + 1'b1;
      end else begin
        col_d = '0;
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Build the item with the thresholds in force when it arrives
  assign q_valid_o                  = in_valid_i;
  assign q_col_o                    = col_cur;
  assign q_row_o                    = row_cur;
  assign q_item_o.pixel             = pixel_value_i;
  assign q_item_o.frame_start       = frame_start_i;
  assign q_item_o.last              = last_col && last_row;
  assign q_item_o.thr.red_min       = red_min_q;
  assign q_item_o.thr.green_max     = green_max_q;
  assign q_item_o.thr.blue_max      = blue_max_q;
  assign q_item_o.thr.red_over_blue = rob_q;
  assign q_item_o.thr.stride        = (stride_q == '0) ? StrideW'(1) : stride_q;
  assign q_item_o.thr.min_pixels    = min_pixels_q;

endmodule

@@ design/cbc_back.sv @@
// Back end: stride test, color classification and per-frame accumulation.
module cbc_back #(
  parameter int unsigned PosW = $clog2(cbc_pkg::MaxFrameDimDefault)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  cbc_pkg::item_t    q_item_i,
  input  logic [PosW-1:0]   q_col_i,
  input  logic [PosW-1:0]   q_row_i,
  input  logic              div_idle_i,
  output logic              div_start_o,
  output cbc_pkg::div_req_t div_req_o
);
  import cbc_pkg::*;

  // Remainder bits handled in the second stage
  localparam int unsigned LoW = PosW / 2;

  logic advance;

  // First stage: upper remainder bits and the color test
  logic               s1_valid_q;
  logic [PosW-1:0]    s1_col_q, s1_row_q;
  logic [StrideW-1:0] s1_rc_q, s1_rr_q, s1_stride_q;
  logic               s1_match_q, s1_fs_q, s1_last_q;
  logic [CountW-1:0]  s1_min_q;
  logic [StrideW-1:0] rc_hi, rr_hi, rc_lo, rr_lo;
  logic [RedW-1:0]    red, blue;
  logic [GreenW-1:0]  green;
  logic               match;

  // Second stage: sample hit
  logic              s2_valid_q;
  logic [PosW-1:0]   s2_col_q, s2_row_q;
  logic              s2_hit_q, s2_fs_q, s2_last_q;
  logic [CountW-1:0] s2_min_q;

  // Frame accumulators
  logic [SumW-1:0]   sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0]   base_x, base_y, next_x, next_y;
  logic [CountW-1:0] base_c, next_c;

  // Hold the whole pipe while a frame end waits for the divider
  assign advance   = !(s2_valid_q && s2_last_q && !div_idle_i);
  assign q_ready_o = advance;

  // Classify the pixel color
  assign red   = q_item_i.pixel[15:11];
  assign green = q_item_i.pixel[10:5];
  assign blue  = q_item_i.pixel[4:0];
  assign match = (red >= q_item_i.thr.red_min) && (green <= q_item_i.thr.green_max) &&
                 (blue <= q_item_i.thr.blue_max) &&
                 ({1'b0, red} > ({1'b0, blue} + {1'b0, q_item_i.thr.red_over_blue}));

  // Reduce the upper position bits modulo the stride
  always_comb begin
    rc_hi = '0;
    rr_hi = '0;
    for (int i = PosW - 1; i >= int'(LoW); i--) begin
      rc_hi = rem_step(rc_hi, q_col_i[i], q_item_i.thr.stride);
      rr_hi = rem_step(rr_hi, q_row_i[i], q_item_i.thr.stride);
    end
  end

  // Finish the remainders on the lower bits
  always_comb begin
    rc_lo = s1_rc_q;
    rr_lo = s1_rr_q;
    for (int i = int'(LoW) - 1; i >= 0; i--) begin
      rc_lo = rem_step(rc_lo, s1_col_q[i], s1_stride_q);
      rr_lo = rem_step(rr_lo, s1_row_q[i], s1_stride_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= q_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_col_q    <= q_col_i;
      s1_row_q    <= q_row_i;
      s1_rc_q     <= rc_hi;
      s1_rr_q     <= rr_hi;
      s1_stride_q <= q_item_i.thr.stride;
      s1_match_q  <= match;
      s1_fs_q     <= q_item_i.frame_start;
      s1_last_q   <= q_item_i.last;
      s1_min_q    <= q_item_i.thr.min_pixels;
      s2_col_q    <= s1_col_q;
      s2_row_q    <= s1_row_q;
      s2_hit_q    <= s1_match_q && (rc_lo == '0) && (rr_lo == '0);
      s2_fs_q     <= s1_fs_q;
      s2_last_q   <= s1_last_q;
      s2_min_q    <= s1_min_q;
    end
  end

  // Add a hit to the sums, starting from zero on a frame start; the count saturates
  assign base_x = s2_fs_q ? '0 : sum_x_q;
  assign base_y = s2_fs_q ? '0 : sum_y_q;
  assign base_c = s2_fs_q ? '0 : cnt_q;
  assign next_x = base_x + (s2_hit_q ? SumW'(s2_col_q) : '0);
  assign next_y = base_y + (s2_hit_q ? SumW'(s2_row_q) : '0);
  assign next_c = (s2_hit_q && (base_c != CountMax)) ? base_c + 1'b1 : base_c;

  always_comb begin
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    cnt_d   = cnt_q;
    if (advance && s2_valid_q) begin
      if (s2_last_q) begin
        sum_x_d = '0;
        sum_y_d = '0;
        cnt_d   = '0;
      end else begin
        sum_x_d = next_x;
        sum_y_d = next_y;
        cnt_d   = next_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      cnt_q   <= '0;
    end else begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hand the frame totals to the divider at the last pixel
  assign div_start_o          = s2_valid_q && s2_last_q && div_idle_i;
  assign div_req_o.sum_x      = next_x;
  assign div_req_o.sum_y      = next_y;
  assign div_req_o.count      = next_c;
  assign div_req_o.min_pixels = s2_min_q;

endmodule

@@ design/cbc_div.sv @@
// Frame result unit: shared bit-serial divider for both centers and the output register.
module cbc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  cbc_pkg::div_req_t           req_i,
  output logic                        idle_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [cbc_pkg::CenterW-1:0] blob_col_o,
  output logic [cbc_pkg::CenterW-1:0] blob_row_o,
  output logic [cbc_pkg::CountW-1:0]  match_count_o
);
  import cbc_pkg::*;

  localparam int unsigned StepW = $clog2(SumW);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDivX = 2'd1;
  localparam logic [1:0] StDivY = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [SumW-1:0]   dvd_q, dvd_d, sum_y_q, sum_y_d;
  logic [CountW-1:0] rem_q, rem_d, cnt_q, cnt_d;
  logic [CenterW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic              found_q, found_d;
  logic              out_valid_q, out_valid_d, load_out;

  logic [CountW:0]   trial, diff;
  logic              fits;
  logic [CountW-1:0] rem_nx;
  logic [SumW-1:0]   dvd_nx;
  logic              found_new;

  // One restoring division step: quotient bits shift in behind the dividend
  assign trial  = {rem_q, dvd_q[SumW-1]};
  assign diff   = trial - {1'b0, cnt_q};
  assign fits   = (trial >= {1'b0, cnt_q});
  assign rem_nx = fits ? diff[CountW-1:0] : trial[CountW-1:0];
  assign dvd_nx = {dvd_q[SumW-2:0], fits};

  assign found_new = (req_i.count >= req_i.min_pixels);
  assign load_out  = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // Sequence: center x, center y, output wait; no target or no matches skips both
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    sum_y_d = sum_y_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    found_d = found_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          dvd_d   = req_i.sum_x;
          sum_y_d = req_i.sum_y;
          cnt_d   = req_i.count;
          rem_d   = '0;
          step_d  = '0;
          found_d = found_new;
          cx_d    = '0;
          cy_d    = '0;
          if (found_new && (req_i.count != '0)) begin
            state_d = StDivX;
          end else begin
            state_d = StDone;
          end
        end
      end
      StDivX: begin
        dvd_d  = dvd_nx;
        rem_d  = rem_nx;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(SumW - 1)) begin
          cx_d    = dvd_nx[CenterW-1:0];
          dvd_d   = sum_y_q;
          rem_d   = '0;
          step_d  = '0;
          state_d = StDivY;
        end
      end
      StDivY: begin
        dvd_d  = dvd_nx;
        rem_d  = rem_nx;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(SumW - 1)) begin
          cy_d    = dvd_nx[CenterW-1:0];
          step_d  = '0;
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output valid sets on load, drops when the item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    sum_y_q <= sum_y_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    found_q <= found_d;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      found_o       <= found_q;
      blob_col_o    <= cx_q;
      blob_row_o    <= cy_q;
      match_count_o <= cnt_q;
    end
  end

  assign idle_o      = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

@@ design/color_blob_centroid_top.sv @@
// Top level of the red blob centroid finder for RGB565 raster streams.
// Throughput: one pixel per cycle; a frame end stalls input only while the divider is busy.
// After the last pixel of a frame is taken it passes the queue and both back stages, then the
//   shared one-bit-per-cycle divider runs x, then y; with no target or no matches it skips both.
// A frame end waits in the back stages until that divider has finished the frame before.
// Reset (async, active low) clears position, sums, queue and result valid; registers take defaults.
module color_blob_centroid_top #(
  parameter int unsigned MaxFrameDim = cbc_pkg::MaxFrameDimDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cbc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cbc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cbc_pkg::PixW-1:0]    pixel_value_i,
  input  logic                        frame_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [cbc_pkg::CenterW-1:0] blob_col_o,
  output logic [cbc_pkg::CenterW-1:0] blob_row_o,
  output logic [cbc_pkg::CountW-1:0]  match_count_o
);
  import cbc_pkg::*;

  localparam int unsigned PosW  = $clog2(MaxFrameDim);
  localparam int unsigned DataW = $bits(item_t) + 2 * PosW;

  logic            f_valid, f_ready, b_valid, b_ready;
  item_t           f_item, b_item;
  logic [PosW-1:0] f_col, f_row, b_col, b_row;
  logic [DataW-1:0] f_data, b_data;
  logic            div_idle, div_start;
  div_req_t        div_req;

  cbc_front #(
    .MaxFrameDim (MaxFrameDim),
    .PosW        (PosW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_value_i (pixel_value_i),
    .frame_start_i (frame_start_i),
    .q_valid_o     (f_valid),
    .q_ready_i     (f_ready),
    .q_item_o      (f_item),
    .q_col_o       (f_col),
    .q_row_o       (f_row)
  );

  // Pack and unpack queue entries
  assign f_data = {f_item, f_col, f_row};
  assign {b_item, b_col, b_row} = b_data;

  cbc_fifo #(
    .DataW (DataW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_data),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_data)
  );

  cbc_back #(
    .PosW (PosW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (b_valid),
    .q_ready_o   (b_ready),
    .q_item_i    (b_item),
    .q_col_i     (b_col),
    .q_row_i     (b_row),
    .div_idle_i  (div_idle),
    .div_start_o (div_start),
    .div_req_o   (div_req)
  );

  cbc_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (div_start),
    .req_i         (div_req),
    .idle_o        (div_idle),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .blob_col_o    (blob_col_o),
    .blob_row_o    (blob_row_o),
    .match_count_o (match_count_o)
  );

endmodule

@@ design/cbc_checker.sv @@
// Port-level checks on the result channel and the register port, bound to the top level.
module cbc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        found_o,
  input logic [cbc_pkg::CenterW-1:0] blob_col_o,
  input logic [cbc_pkg::CenterW-1:0] blob_row_o,
  input logic [cbc_pkg::CountW-1:0]  match_count_o
);

  // Stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) &&
    $stable(blob_col_o) && $stable(blob_row_o) && $stable(match_count_o))
    else $error("result changed while stalled");

  // No target means both centers read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> blob_col_o == '0 && blob_row_o == '0)
    else $error("centers nonzero without a target");

  // A found target with no matches has zero centers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o && match_count_o == '0 |-> blob_col_o == '0 && blob_row_o == '0)
    else $error("centers nonzero with zero matches");

  // Reset empties the result channel by the next edge and keeps the register port open
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && cfg_ready_o)
    else $error("result valid or register port closed after reset");

endmodule

bind color_blob_centroid_top cbc_checker u_cbc_checker (.*);
